[hw/rtl/hgls_pkg.sv]
// Shared types and constants for the Hessenberg least-squares solver.
package hgls_pkg;

	localparam int unsigned ACC_W = 72;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ROT_RD,
		ST_ROT_RDW,
		ST_ROT_T,
		ST_ROT_TW,
		ST_ROT_U,
		ST_ROT_SQ,
		ST_ROT_SQW,
		ST_ROT_INV,
		ST_ROT_INVW,
		ST_ROT_OTH,
		ST_ROT_CS,
		ST_APP_RD,
		ST_APP_RDW,
		ST_APP_M1,
		ST_APP_M2,
		ST_APP_M3,
		ST_APP_M4,
		ST_APP_WR,
		ST_BS_RD,
		ST_BS_RDW,
		ST_BS_MUL,
		ST_BS_ACC,
		ST_BS_DIV,
		ST_BS_DIVW,
		ST_BS_WR,
		ST_OUT_RD,
		ST_OUT_RDW,
		ST_OUT_SEND
	} state_t;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_START = 1'b1
	} op_t;

	typedef struct packed {
		logic start;
		logic [ACC_W-1:0] num;
		logic [ACC_W-1:0] den;
	} div_req_t;

	function automatic logic [63:0] round_shift(input logic signed [ACC_W-1:0] v,
			input int unsigned n);
		logic [ACC_W-1:0] m;
		logic [ACC_W-1:0] r;
		begin
			m = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
			r = (m + (ACC_W'(1) << (n - 1))) >> n;
			round_shift = v[ACC_W-1] ? 64'(-r) : 64'(r);
		end
	endfunction

endpackage

[hw/rtl/hgls_div.sv]
// Iterative restoring divider and square root, one quotient bit per cycle.
module hgls_div
	import hgls_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  div_req_t         req,
	input  logic             sqrt_mode,
	output logic             busy,
	output logic [ACC_W-1:0] result
);

	localparam int unsigned CNT_W = $clog2(ACC_W + 1);

	logic [ACC_W-1:0] rem_q;
	logic [ACC_W-1:0] num_q;
	logic [ACC_W-1:0] den_q;
	logic [ACC_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             sq_q;
	logic [ACC_W-1:0] rem_sh;
	logic [ACC_W-1:0] trial;
	logic [ACC_W-1:0] sq_bit;

	assign busy   = cnt_q != '0;
	assign result = quo_q;
	assign rem_sh = {rem_q[ACC_W-2:0], num_q[ACC_W-1]};
	assign sq_bit = ACC_W'(1) << (2 * (cnt_q - 1'b1));
	assign trial  = quo_q + sq_bit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= sqrt_mode ? CNT_W'(ACC_W / 2) : CNT_W'(ACC_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= sqrt_mode ? req.num : '0;
			num_q <= req.num;
			den_q <= req.den;
			quo_q <= '0;
			sq_q  <= sqrt_mode;
		end else if (busy) begin
			if (sq_q) begin
				if (rem_q >= trial) begin
					rem_q <= rem_q - trial;
					quo_q <= (quo_q >> 1) + sq_bit;
				end else begin
					quo_q <= quo_q >> 1;
				end
			end else begin
				num_q <= num_q << 1;
				if (rem_sh >= den_q) begin
					rem_q <= rem_sh - den_q;
					quo_q <= {quo_q[ACC_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[ACC_W-2:0], 1'b0};
				end
			end
		end
	end

endmodule

[hw/rtl/hessenberg_givens_least_squares.sv]
// Top level of the Hessenberg least-squares solver.
// Load beats (tuser operation 0) write one matrix entry each. A start beat runs a Givens
// QR over the stored matrix and a back substitution, then emits KRYLOV_DIM solution beats
// with the residual on the tlast beat. The solve is bound by one shared 32x32 multiplier
// and one bit-serial divide/root unit: per column the rotation takes two divides and one
// root, then each rotated pair, including the right-hand-side pair, goes through the
// multiplier; each back-substitution row takes one product per term plus a divide. The
// block accepts no beat until it has sent the last solution beat.
module hessenberg_givens_least_squares
	import hgls_pkg::*;
#(
	parameter int KRYLOV_DIM = 16,
	parameter int WORD_BITS  = 32
)
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // row[4:0], col[8:5], value[40:9]
	input  logic        s_tuser,   // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // index[3:0], solution[35:4], residual[66:36], zero_pivot[67]
	output logic        m_tlast
);

	localparam int N     = KRYLOV_DIM;
	localparam int ROWS  = N + 1;
	localparam int SATB  = (WORD_BITS > 32) ? 32 : WORD_BITS;
	localparam int CW    = $clog2(ROWS + 1);
	localparam int HD    = ROWS * N;
	localparam int HA    = $clog2(HD);
	localparam int RA    = $clog2(ROWS);
	localparam int SA    = (N > 1) ? $clog2(N) : 1;
	localparam logic signed [63:0] WMAX = (64'sd1 <<< (SATB - 1)) - 64'sd1;
	localparam logic signed [63:0] WMIN = -WMAX - 64'sd1;
	localparam logic [ACC_W-1:0] Q30 = ACC_W'(1) << 30;

	function automatic logic signed [31:0] sat(input logic signed [63:0] v);
		begin
			if (v > WMAX) sat = 32'(WMAX);
			else if (v < WMIN) sat = 32'(WMIN);
			else sat = v[31:0];
		end
	endfunction

	logic signed [31:0] hmem [HD];
	logic signed [31:0] rmem [ROWS];
	logic signed [31:0] ymem [N];

	state_t state_q, state_d;
	logic [CW-1:0] i_q, j_q;
	logic signed [31:0] a_q, b_q, x_q, yv_q;
	logic [ACC_W-1:0] t_q, inv_q;
	logic [ACC_W-1:0] u_now;
	logic signed [31:0] c_q, s_q;
	logic sw_q, neg_q, zp_q, rhs_q;
	logic signed [ACC_W-1:0] p1_q, p2_q, acc_q;
	logic signed [63:0] prod_s1;
	logic signed [31:0] ma_q, mb_q;
	logic signed [31:0] hrd_q, rrd_q, yrd_q;
	logic [31:0] resid_q;
	div_req_t dreq;
	logic sqm;
	logic dbusy;
	logic [ACC_W-1:0] dres;

	logic s_fire, m_fire;
	logic [4:0] ld_row;
	logic [3:0] ld_col;
	logic signed [31:0] ld_val;

	assign ld_row = s_tdata[4:0];
	assign ld_col = s_tdata[8:5];
	assign ld_val = s_tdata[40:9];
	assign s_fire = s_tvalid && s_tready;
	assign m_fire = m_tvalid && m_tready;

	hgls_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (dreq),
		.sqrt_mode(sqm),
		.busy     (dbusy),
		.result   (dres)
	);

	// addresses
	logic [HA-1:0] h_top, h_bot, h_ij;
	assign h_top = HA'(i_q * N + j_q);
	assign h_bot = HA'((i_q + 1) * N + j_q);
	assign h_ij  = h_top;

	// shared multiplier
	always_ff @(posedge clk) begin
		prod_s1 <= 64'(ma_q) * 64'(mb_q);
	end

	logic [31:0] mag_a, mag_b;
	assign mag_a = a_q[31] ? 32'(-a_q) : 32'(a_q);
	assign mag_b = b_q[31] ? 32'(-b_q) : 32'(b_q);
	assign u_now = Q30 + ((ACC_W'(unsigned'(prod_s1)) + (Q30 >> 1)) >> 30);

	logic signed [31:0] acc_sat;
	assign acc_sat = sat(64'(acc_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		dreq     = '0;
		sqm      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_fire && s_tuser == OP_START) state_d = ST_ROT_RD;
			end
			ST_ROT_RD: state_d = (i_q == CW'(N)) ? ST_BS_RD : ST_ROT_RDW;
			ST_ROT_RDW: state_d = ST_ROT_T;
			ST_ROT_T: begin
				if (b_q == 0) begin
					state_d = ST_APP_RD;
				end else begin
					dreq.start = 1'b1;
					dreq.num = (mag_b > mag_a) ? ACC_W'(mag_a) << 30 : ACC_W'(mag_b) << 30;
					dreq.den = (mag_b > mag_a) ? ACC_W'(mag_b) : ACC_W'(mag_a);
					state_d = ST_ROT_TW;
				end
			end
			ST_ROT_TW: if (!dbusy) state_d = ST_ROT_U;
			ST_ROT_U: state_d = ST_ROT_SQ;
			ST_ROT_SQ: begin
				dreq.start = 1'b1;
				dreq.num = u_now << 30;
				sqm = 1'b1;
				state_d = ST_ROT_SQW;
			end
			ST_ROT_SQW: begin
				sqm = 1'b1;
				if (!dbusy) state_d = ST_ROT_INV;
			end
			ST_ROT_INV: begin
				dreq.start = 1'b1;
				dreq.num = (ACC_W'(1) << 60) + (dres >> 1);
				dreq.den = dres;
				state_d = ST_ROT_INVW;
			end
			ST_ROT_INVW: if (!dbusy) state_d = ST_ROT_OTH;
			ST_ROT_OTH: state_d = ST_ROT_CS;
			ST_ROT_CS: state_d = ST_APP_RD;
			ST_APP_RD: state_d = ST_APP_RDW;
			ST_APP_RDW: state_d = ST_APP_M1;
			ST_APP_M1: state_d = ST_APP_M2;
			ST_APP_M2: state_d = ST_APP_M3;
			ST_APP_M3: state_d = ST_APP_M4;
			ST_APP_M4: state_d = ST_APP_WR;
			ST_APP_WR: begin
				if (rhs_q) state_d = ST_ROT_RD;
				else state_d = ST_APP_RD;
			end
			ST_BS_RD: state_d = ST_BS_RDW;
			ST_BS_RDW: state_d = (j_q == CW'(N)) ? ST_BS_DIV : ST_BS_MUL;
			ST_BS_MUL: state_d = ST_BS_ACC;
			ST_BS_ACC: state_d = ST_BS_RD;
			ST_BS_DIV: begin
				if (hrd_q != 0) begin
					dreq.start = 1'b1;
					dreq.num = ((acc_sat[31] ? ACC_W'(-acc_sat) : ACC_W'(acc_sat)) << 16)
						+ ((hrd_q[31] ? ACC_W'(-hrd_q) : ACC_W'(hrd_q)) >> 1);
					dreq.den = hrd_q[31] ? ACC_W'(-hrd_q) : ACC_W'(hrd_q);
				end
				state_d = ST_BS_DIVW;
			end
			ST_BS_DIVW: if (!dbusy) state_d = ST_BS_WR;
			ST_BS_WR: state_d = (i_q == '0) ? ST_OUT_RD : ST_BS_RD;
			ST_OUT_RD: state_d = ST_OUT_RDW;
			ST_OUT_RDW: state_d = ST_OUT_SEND;
			ST_OUT_SEND: begin
				if (m_fire) state_d = (i_q == CW'(N - 1)) ? ST_IDLE : ST_OUT_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	logic [63:0] qsat;
	logic signed [63:0] qs;
	assign qsat = (dres > ACC_W'(WMAX + 1)) ? 64'(WMAX + 1) : dres[63:0];
	assign qs = (acc_q[ACC_W-1] != hrd_q[31]) ? -$signed(qsat) : $signed(qsat);

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_fire) begin
					if (s_tuser == OP_LOAD) begin
						if (32'(ld_row) < 32'(ROWS) && 32'(ld_col) < 32'(N))
							hmem[HA'(32'(ld_row) * N + 32'(ld_col))] <= sat(64'(ld_val));
					end else begin
						rmem[0] <= sat(64'(ld_val));
						for (int k = 1; k < ROWS; k++) rmem[k] <= '0;
						i_q  <= '0;
						zp_q <= 1'b0;
					end
				end
			end
			ST_ROT_RD: begin
				j_q <= i_q;
				rhs_q <= 1'b0;
				if (i_q != CW'(N)) begin
					hrd_q <= hmem[HA'(i_q * N + i_q)];
					yrd_q <= hmem[HA'((i_q + 1) * N + i_q)];
				end else begin
					i_q <= CW'(N - 1);
					j_q <= CW'(N);
					acc_q <= ACC_W'(rmem[RA'(N - 1)]);
				end
			end
			ST_ROT_RDW: begin
				a_q <= hrd_q;
				b_q <= yrd_q;
			end
			ST_ROT_T: begin
				c_q <= 32'sd1 <<< 30;
				s_q <= '0;
				sw_q <= mag_b > mag_a;
				neg_q <= a_q[31] != b_q[31];
			end
			ST_ROT_TW: begin
				t_q <= dres;
				ma_q <= 32'(dres);
				mb_q <= 32'(dres);
			end
			ST_ROT_U: ;
			ST_ROT_INVW: begin
				inv_q <= (dres > Q30) ? Q30 : dres;
				ma_q <= (dres > Q30) ? 32'(Q30) : 32'(dres);
				mb_q <= 32'(t_q);
			end
			ST_ROT_OTH: ;
			ST_ROT_CS: begin
				if (sw_q) begin
					s_q <= 32'(inv_q);
					c_q <= neg_q ? -32'(((ACC_W'(unsigned'(prod_s1)) + (Q30 >> 1)) >> 30))
						: 32'(((ACC_W'(unsigned'(prod_s1)) + (Q30 >> 1)) >> 30));
				end else begin
					c_q <= 32'(inv_q);
					s_q <= neg_q ? -32'(((ACC_W'(unsigned'(prod_s1)) + (Q30 >> 1)) >> 30))
						: 32'(((ACC_W'(unsigned'(prod_s1)) + (Q30 >> 1)) >> 30));
				end
			end
			ST_APP_RD: begin
				if (rhs_q) begin
					hrd_q <= rmem[RA'(i_q)];
					yrd_q <= rmem[RA'(i_q + 1)];
				end else begin
					hrd_q <= hmem[h_top];
					yrd_q <= hmem[h_bot];
				end
			end
			ST_APP_RDW: begin
				x_q <= hrd_q;
				yv_q <= yrd_q;
				ma_q <= c_q;
				mb_q <= hrd_q;
			end
			ST_APP_M1: begin
				ma_q <= s_q;
				mb_q <= yv_q;
			end
			ST_APP_M2: begin
				p1_q <= ACC_W'(prod_s1);
				ma_q <= c_q;
				mb_q <= yv_q;
			end
			ST_APP_M3: begin
				p1_q <= p1_q + ACC_W'(prod_s1);
				ma_q <= s_q;
				mb_q <= x_q;
			end
			ST_APP_M4: p2_q <= ACC_W'(prod_s1);
			ST_APP_WR: begin
				if (rhs_q) begin
					rmem[RA'(i_q)] <= sat(round_shift(p1_q, 30));
					rmem[RA'(i_q + 1)] <= sat(round_shift(p2_q - ACC_W'(prod_s1), 30));
					i_q <= i_q + 1'b1;
				end else begin
					hmem[h_top] <= sat(round_shift(p1_q, 30));
					hmem[h_bot] <= (j_q == i_q) ? '0
						: sat(round_shift(p2_q - ACC_W'(prod_s1), 30));
					if (j_q == CW'(N - 1)) rhs_q <= 1'b1;
					else j_q <= j_q + 1'b1;
				end
			end
			ST_BS_RD: begin
				if (j_q == CW'(N)) begin
					hrd_q <= hmem[HA'(i_q * N + i_q)];
				end else begin
					hrd_q <= hmem[h_ij];
					yrd_q <= ymem[SA'(j_q)];
				end
			end
			ST_BS_RDW: begin
				ma_q <= hrd_q;
				mb_q <= yrd_q;
			end
			ST_BS_MUL: ;
			ST_BS_ACC: begin
				acc_q <= acc_q - ACC_W'($signed(round_shift(ACC_W'(prod_s1), 16)));
				j_q <= j_q + 1'b1;
			end
			ST_BS_DIV: acc_q <= ACC_W'(acc_sat);
			ST_BS_WR: begin
				if (hrd_q == 0) begin
					zp_q <= 1'b1;
					ymem[SA'(i_q)] <= (acc_q > 0) ? 32'(WMAX) : ((acc_q < 0) ? 32'(WMIN) : '0);
				end else begin
					ymem[SA'(i_q)] <= sat(qs);
				end
				if (i_q != '0) begin
					i_q <= i_q - 1'b1;
					j_q <= i_q;
					acc_q <= ACC_W'(rmem[RA'(i_q - 1'b1)]);
				end else begin
					resid_q <= (rmem[RA'(N)][31] ? 32'(sat(-64'(rmem[RA'(N)])))
						: 32'(rmem[RA'(N)]));
				end
			end
			ST_OUT_RD: yrd_q <= ymem[SA'(i_q)];
			ST_OUT_SEND: if (m_fire) i_q <= i_q + 1'b1;
			default: ;
		endcase
	end

	always_comb begin
		m_tvalid = state_q == ST_OUT_SEND;
		m_tlast  = i_q == CW'(N - 1);
		m_tdata  = '0;
		m_tdata[3:0]   = 4'(i_q);
		m_tdata[35:4]  = yrd_q;
		m_tdata[66:36] = m_tlast ? resid_q[30:0] : '0;
		m_tdata[67]    = zp_q;
	end

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the Givens QR Hessenberg least-squares solver.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import hgls_pkg::*;

	localparam int DIM = 16;
	localparam int NROW = DIM + 1;
	localparam longint WMAXV = 64'sd2147483647;
	localparam longint WMINV = -64'sd2147483648;
	localparam longint ONE30 = 64'sd1 << 30;
	localparam int WATCH_LIMIT = 100000;

	typedef struct {
		op_t       op;
		bit [4:0]  row;
		bit [3:0]  col;
		bit [31:0] val;
	} item_t;

	typedef struct {
		bit [3:0]  index;
		bit [31:0] solution;
		bit [30:0] residual;
		bit        zero_pivot;
		bit        last;
	} sol_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;   // row[4:0], col[8:5], value[40:9]
	logic        s_tuser = 1'b0; // operation
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;        // index[3:0], solution[35:4], residual[66:36], zero_pivot[67]
	logic        m_tlast;

	item_t     pending_items[$];
	sol_beat_t expected_solutions[$];
	item_t     cur_item;
	longint    hmat[NROW][DIM];
	longint    rhs[NROW];
	longint    ysol[DIM];
	int        errors = 0;
	int        cycle = 0;
	int        quiet = 0;

	hessenberg_givens_least_squares dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint sat32(longint v);
		if (v > WMAXV) return WMAXV;
		if (v < WMINV) return WMINV;
		return v;
	endfunction

	function automatic longint unsigned magn(longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint round_off(longint v, int n);
		longint unsigned m;
		m = (magn(v) + (64'd1 << (n - 1))) >> n;
		return v < 0 ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	task automatic givens(input longint a, input longint b, output longint c, output longint s);
		longint unsigned ma, mb, t, u, r, inv, oth;
		longint other;
		ma = magn(a);
		mb = magn(b);
		if (b == 0) begin
			c = ONE30;
			s = 0;
			return;
		end
		if (mb > ma) t = (ma << 30) / mb;
		else t = (mb << 30) / ma;
		u = ONE30 + ((t * t + (ONE30 >> 1)) >> 30);
		r = int_sqrt(u << 30);
		inv = ((64'd1 << 60) + (r >> 1)) / r;
		if (inv > ONE30) inv = ONE30;
		oth = (inv * t + (ONE30 >> 1)) >> 30;
		other = ((a < 0) != (b < 0)) ? -longint'(oth) : longint'(oth);
		if (mb > ma) begin
			s = inv;
			c = other;
		end else begin
			c = inv;
			s = other;
		end
	endtask

	task automatic rotate(inout longint x, inout longint y, input longint c, input longint s);
		longint xv, yv;
		xv = x;
		yv = y;
		x = sat32(round_off(c * xv + s * yv, 30));
		y = sat32(round_off(c * yv - s * xv, 30));
	endtask

	task automatic solve_and_predict(input item_t it);
		longint c, s, acc, d, resid, qs;
		longint unsigned md, q;
		bit zp;
		sol_beat_t b;
		zp = 0;
		if (it.op == OP_LOAD) begin
			if (it.row < NROW)
				hmat[it.row][it.col] = longint'($signed(it.val));
			return;
		end
		rhs[0] = longint'($signed(it.val));
		for (int i = 1; i < NROW; i++) rhs[i] = 0;
		for (int i = 0; i < DIM; i++) begin
			givens(hmat[i][i], hmat[i+1][i], c, s);
			for (int j = i; j < DIM; j++) rotate(hmat[i][j], hmat[i+1][j], c, s);
			hmat[i+1][i] = 0;
			rotate(rhs[i], rhs[i+1], c, s);
		end
		for (int i = DIM - 1; i >= 0; i--) begin
			d = hmat[i][i];
			acc = rhs[i];
			for (int j = i + 1; j < DIM; j++) acc -= round_off(hmat[i][j] * ysol[j], 16);
			acc = sat32(acc);
			if (d == 0) begin
				zp = 1;
				ysol[i] = acc > 0 ? WMAXV : (acc < 0 ? WMINV : 0);
			end else begin
				md = magn(d);
				q = ((magn(acc) << 16) + (md >> 1)) / md;
				qs = (q > 64'd2147483648) ? 64'sd2147483648 : longint'(q);
				ysol[i] = sat32(((acc < 0) != (d < 0)) ? -qs : qs);
			end
		end
		resid = longint'(magn(rhs[DIM]));
		if (resid > WMAXV) resid = WMAXV;
		for (int k = 0; k < DIM; k++) begin
			b.index = k[3:0];
			b.solution = ysol[k][31:0];
			b.residual = (k == DIM - 1) ? resid[30:0] : 31'd0;
			b.zero_pivot = zp;
			b.last = (k == DIM - 1);
			expected_solutions.push_back(b);
		end
	endtask

	function automatic bit idle_now();
		return (cycle % 40000 < 28000) && ($urandom_range(99) < 10);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) solve_and_predict(cur_item);
			if (!s_tvalid || s_tready) begin
				if (pending_items.size() > 0 && !idle_now()) begin
					cur_item = pending_items.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= cur_item.op;
					s_tdata <= {7'd0, cur_item.val, cur_item.col, cur_item.row};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= !idle_now();
		end
	end

	always @(posedge clk) begin
		sol_beat_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_solutions.size() == 0) begin
				$error("unexpected solution beat %h", m_tdata);
				errors++;
			end else begin
				e = expected_solutions.pop_front();
				if (m_tdata[3:0] !== e.index) begin
					$error("index expected %0d actual %0d", e.index, m_tdata[3:0]);
					errors++;
				end
				if (m_tdata[35:4] !== e.solution) begin
					$error("solution expected %h actual %h", e.solution, m_tdata[35:4]);
					errors++;
				end
				if (m_tdata[66:36] !== e.residual) begin
					$error("residual expected %h actual %h", e.residual, m_tdata[66:36]);
					errors++;
				end
				if (m_tdata[67] !== e.zero_pivot) begin
					$error("zero_pivot expected %0d actual %0d", e.zero_pivot, m_tdata[67]);
					errors++;
				end
				if (m_tlast !== e.last) begin
					$error("last expected %0d actual %0d", e.last, m_tlast);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet <= 0;
		end else if (quiet >= WATCH_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic add_load(input int r, input int c, input bit [31:0] v);
		item_t it;
		it.op = OP_LOAD;
		it.row = r[4:0];
		it.col = c[3:0];
		it.val = v;
		pending_items.push_back(it);
	endtask

	task automatic add_start(input bit [31:0] v);
		item_t it;
		it.op = OP_START;
		it.row = 5'($urandom);
		it.col = 4'($urandom);
		it.val = v;
		pending_items.push_back(it);
	endtask

	function automatic bit [31:0] pick_value();
		case ($urandom_range(9))
			0: return $urandom;
			1: return 32'h0;
			2: return 32'h8000_0000;
			3: return 32'h7fff_ffff;
			default: return 32'($urandom_range(262144) - 131072);
		endcase
	endfunction

	task automatic load_full_matrix();
		for (int r = 0; r < NROW; r++)
			for (int c = 0; c < DIM; c++)
				if (r <= c + 1)
					add_load(r, c, (r == c) ? 32'h0002_0000 + $urandom_range(65535)
						: 32'($urandom_range(131072) - 65536));
	endtask

	initial begin
		int nrand;
		int nl;
		load_full_matrix();
		add_start(32'h0001_0000);
		add_start(32'h0001_0000);
		add_load(31, 15, 32'hffff_ffff);
		add_load(17, 0, 32'h1234_5678);
		add_load(16, 0, 32'h7fff_ffff);
		add_load(0, 0, 32'h0);
		add_load(1, 0, 32'h0);
		add_start(32'h7fff_ffff);
		add_load(0, 0, 32'h8000_0000);
		add_load(5, 4, 32'h0);
		add_load(15, 15, 32'h7fff_ffff);
		add_load(16, 15, 32'h8000_0000);
		add_start(32'h8000_0000);
		add_start(32'h0);
		load_full_matrix();
		add_start(32'hffff_0000);
		nrand = 0;
		while (nrand < 140) begin
			nl = $urandom_range(1, 12);
			for (int i = 0; i < nl; i++) begin
				int r, c;
				if ($urandom_range(9) < 2) begin
					r = $urandom_range(31);
					c = $urandom_range(15);
				end else begin
					c = $urandom_range(15);
					r = $urandom_range(c + 1);
				end
				add_load(r, c, pick_value());
				nrand++;
			end
			if ($urandom_range(9) == 0) add_start(pick_value());
			add_start(pick_value());
			nrand++;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_items.size() == 0 && !s_tvalid);
		wait (expected_solutions.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0 && expected_solutions.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
